FILE: rtl/indent_block_token_inserter_assert.svh
// assertion macros for the block token inserter
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef INDENT_BLOCK_TOKEN_INSERTER_ASSERT_SVH
`define INDENT_BLOCK_TOKEN_INSERTER_ASSERT_SVH

// condition holds at every edge out of reset
`define IBTI_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define IBTI_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define IBTI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ibti_pkg.sv
// shared types and codes for the block token inserter
// no dependencies
package ibti_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int LEVEL_BITS_DEF  = 8;

    localparam int CMD_W    = 2;
    localparam int INDENT_W = 8;
    localparam int LINE_W   = 20;
    localparam int COL_W    = 12;
    localparam int TAG_W    = 16;
    localparam int KIND_W   = 3;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [KIND_W-1:0] t_kind;

    localparam t_cmd CMD_LINE_WS   = 2'd0;
    localparam t_cmd CMD_INLINE_WS = 2'd1;
    localparam t_cmd CMD_TOKEN     = 2'd2;
    localparam t_cmd CMD_EOF       = 2'd3;

    localparam t_kind K_PASS  = 3'd0;
    localparam t_kind K_BEGIN = 3'd1;
    localparam t_kind K_END   = 3'd2;
    localparam t_kind K_SEQ   = 3'd3;
    localparam t_kind K_EOF   = 3'd4;
    localparam t_kind K_OVF   = 3'd5;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_ctl;

endpackage

FILE: rtl/ibti_tok_if.sv
// token channel: valid/ready handshake with token payload
// depends on ibti_pkg
interface ibti_tok_if import ibti_pkg::*;;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [INDENT_W-1:0] indent;
    logic [LINE_W-1:0]   src_line;
    logic [COL_W-1:0]    column;
    logic [TAG_W-1:0]    tag;

    modport source (output valid, cmd, indent, src_line, column, tag, input ready);
    modport sink   (input valid, cmd, indent, src_line, column, tag, output ready);
endinterface

FILE: rtl/ibti_res_if.sv
// result channel: valid/ready handshake with result payload
// depends on ibti_pkg
interface ibti_res_if import ibti_pkg::*;;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [LINE_W-1:0] out_line;
    logic [COL_W-1:0]  out_column;
    logic [TAG_W-1:0]  out_tag;
    logic              last;

    modport source (output valid, kind, out_line, out_column, out_tag, last, input ready);
    modport sink   (input valid, kind, out_line, out_column, out_tag, last, output ready);
endinterface

FILE: rtl/ibti_cell.sv
// one stack cell: holds one indent level, shifts with its neighbours
// depends on ibti_pkg
module ibti_cell
    import ibti_pkg::*;
#(
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  t_stack_ctl            i_ctl,
    input  logic [LEVEL_BITS-1:0] i_above,
    input  logic [LEVEL_BITS-1:0] i_below,
    output logic [LEVEL_BITS-1:0] o_level
);

    logic [LEVEL_BITS-1:0] r_level;
    logic [LEVEL_BITS-1:0] n_level;

    always_comb begin
        priority if (i_ctl.push) begin
            n_level = i_above;
        end else if (i_ctl.pop) begin
            n_level = i_below;
        end else begin
            n_level = r_level;
        end
    end

    always_ff @(posedge i_clk) begin
        r_level <= n_level;
    end

    assign o_level = r_level;

endmodule

FILE: rtl/ibti_stack.sv
// indent level stack as a chain of cells, top of stack in cell 0
// depends on ibti_pkg, ibti_cell
module ibti_stack
    import ibti_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int LEVEL_BITS  = LEVEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  t_stack_ctl            i_ctl,
    input  logic [LEVEL_BITS-1:0] i_level,
    output logic [LEVEL_BITS-1:0] o_top,
    output logic [LEVEL_BITS-1:0] o_second
);

    logic [LEVEL_BITS-1:0] w_lvl [STACK_DEPTH];

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [LEVEL_BITS-1:0] w_above;
        logic [LEVEL_BITS-1:0] w_below;

        if (g == 0) begin : g_head
            assign w_above = i_level;
        end else begin : g_body
            assign w_above = w_lvl[g-1];
        end

        if (g == STACK_DEPTH - 1) begin : g_tail
            assign w_below = w_lvl[g];
        end else begin : g_inner
            assign w_below = w_lvl[g+1];
        end

        ibti_cell #(
            .LEVEL_BITS (LEVEL_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_above (w_above),
            .i_below (w_below),
            .o_level (w_lvl[g])
        );
    end

    assign o_top = w_lvl[0];

    if (STACK_DEPTH > 1) begin : g_second
        assign o_second = w_lvl[1];
    end else begin : g_single
        assign o_second = w_lvl[0];
    end

endmodule

FILE: rtl/indent_block_token_inserter.sv
// top level of the offside-rule block token inserter
// depends on ibti_pkg, ibti_tok_if, ibti_res_if, ibti_stack and the assertion header
//
//   channel  dir  modport  payload
//   i_tok    in   sink     cmd, indent, src_line, column, tag
//   o_res    out  source   kind, out_line, out_column, out_tag, last
//
// while output is not stalled: one result per cycle from a single output register;
// an item giving n results blocks further input until its last result is out, so
// plain tokens run at one per cycle; dedent and end of file pop one cell-chain level
// per cycle; synchronous active-low reset empties the stack and the output register
// a stalled output holds the result and stops both popping and input
`include "indent_block_token_inserter_assert.svh"

module indent_block_token_inserter
    import ibti_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int LEVEL_BITS  = LEVEL_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ibti_tok_if.sink   i_tok,
    ibti_res_if.source o_res
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_EOF  = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [LEVEL_BITS-1:0] r_lvl, n_lvl;
    logic [LINE_W-1:0]     r_line, n_line;
    logic [COL_W-1:0]      r_col, n_col;
    logic [TAG_W-1:0]      r_tag, n_tag;

    logic                  r_out_valid, n_out_valid;
    t_kind                 r_kind;
    logic [LINE_W-1:0]     r_out_line;
    logic [COL_W-1:0]      r_out_col;
    logic [TAG_W-1:0]      r_out_tag;
    logic                  r_last;

    t_stack_ctl            s_ctl;
    logic [LEVEL_BITS-1:0] w_lvl_in;
    logic [LEVEL_BITS-1:0] w_stk_top, w_stk_second;
    logic [LEVEL_BITS-1:0] w_top, w_second;
    logic                  w_can_emit;
    logic                  w_emit;
    t_kind                 w_kind;
    logic [TAG_W-1:0]      w_tag;
    logic                  w_last;
    logic                  w_in_ready;

    assign w_lvl_in   = LEVEL_BITS'(i_tok.indent);
    assign w_can_emit = !r_out_valid || o_res.ready;
    assign w_top      = (r_count == '0) ? '0 : w_stk_top;
    assign w_second   = (r_count > CNT_W'(1)) ? w_stk_second : '0;

    ibti_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .LEVEL_BITS  (LEVEL_BITS)
    ) u_stack (
        .i_clk    (i_clk),
        .i_ctl    (s_ctl),
        .i_level  (w_lvl_in),
        .o_top    (w_stk_top),
        .o_second (w_stk_second)
    );

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_lvl      = r_lvl;
        n_line     = r_line;
        n_col      = r_col;
        n_tag      = r_tag;
        s_ctl      = '0;
        w_emit     = 1'b0;
        w_kind     = K_PASS;
        w_tag      = '0;
        w_last     = 1'b0;
        w_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                w_in_ready = w_can_emit;
                if (i_tok.valid && w_can_emit) begin
                    w_emit = 1'b1;
                    n_lvl  = w_lvl_in;
                    n_line = i_tok.src_line;
                    n_col  = i_tok.column;
                    n_tag  = i_tok.tag;
                    unique case (i_tok.cmd)
                        CMD_LINE_WS: begin
                            priority if (w_lvl_in > w_top) begin
                                w_last = 1'b1;
                                if (r_count < CNT_W'(STACK_DEPTH)) begin
                                    s_ctl.push = 1'b1;
                                    n_count    = r_count + CNT_W'(1);
                                    w_kind     = K_BEGIN;
                                end else begin
                                    w_kind = K_OVF;
                                end
                            end else if (w_lvl_in == w_top) begin
                                w_kind = K_SEQ;
                                w_last = 1'b1;
                            end else begin
                                s_ctl.pop = 1'b1;
                                n_count   = r_count - CNT_W'(1);
                                w_kind    = K_END;
                                w_last    = !(w_second > w_lvl_in);
                                if (!w_last) begin
                                    n_state = S_POP;
                                end
                            end
                        end
                        CMD_EOF: begin
                            if (r_count == '0) begin
                                w_kind = K_EOF;
                                w_tag  = i_tok.tag;
                                w_last = 1'b1;
                            end else begin
                                s_ctl.pop = 1'b1;
                                n_count   = r_count - CNT_W'(1);
                                w_kind    = K_END;
                                n_state   = S_EOF;
                            end
                        end
                        default: begin
                            w_kind = K_PASS;
                            w_tag  = i_tok.tag;
                            w_last = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                if (w_can_emit) begin
                    w_emit    = 1'b1;
                    s_ctl.pop = 1'b1;
                    n_count   = r_count - CNT_W'(1);
                    w_kind    = K_END;
                    w_last    = !(w_second > r_lvl);
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EOF: begin
                if (w_can_emit) begin
                    w_emit = 1'b1;
                    if (r_count == '0) begin
                        w_kind  = K_EOF;
                        w_tag   = r_tag;
                        w_last  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        s_ctl.pop = 1'b1;
                        n_count   = r_count - CNT_W'(1);
                        w_kind    = K_END;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = w_emit || (r_out_valid && !o_res.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl  <= n_lvl;
        r_line <= n_line;
        r_col  <= n_col;
        r_tag  <= n_tag;
        if (w_emit) begin
            r_kind     <= w_kind;
            r_out_line <= n_line;
            r_out_col  <= n_col;
            r_out_tag  <= w_tag;
            r_last     <= w_last;
        end
    end

    assign i_tok.ready      = w_in_ready;
    assign o_res.valid      = r_out_valid;
    assign o_res.kind       = r_kind;
    assign o_res.out_line   = r_out_line;
    assign o_res.out_column = r_out_col;
    assign o_res.out_tag    = r_out_tag;
    assign o_res.last       = r_last;

    `IBTI_ASSERT_ALWAYS(a_count_range, r_count <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
    `IBTI_ASSERT_IMPL(a_pop_nonempty, s_ctl.pop, r_count != '0, "pop from empty stack")
    `IBTI_ASSERT_IMPL(a_push_pop_excl, s_ctl.push, !s_ctl.pop, "push and pop together")
    `IBTI_ASSERT_IMPL(a_dedent_open, r_state == S_POP, r_count != '0, "dedent with no open level")
    `IBTI_ASSERT_NEXT(a_busy_result, r_state != S_IDLE, o_res.valid, "no result while busy")

endmodule
